### rtl/bdeq_pkg.sv
package bdeq_pkg;

    localparam int DEPTH  = 128;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int JOB_W  = 32;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_REAR  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_REAR   = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic take_read;
    } cmd_t;

    typedef struct packed {
        logic pop_ok;
    } dp_stat_t;

endpackage

### rtl/bdeq_ram.sv
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/bdeq_ctrl.sv
module bdeq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  bdeq_pkg::dp_stat_t  stat,
    output bdeq_pkg::cmd_t      cmd
);
    import bdeq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.execute = 1'b1;
                state_next  = stat.pop_ok ? ST_READ : ST_OUT;
            end
            ST_READ: begin
                cmd.take_read = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/bdeq_dp.sv
module bdeq_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bdeq_pkg::cmd_t                      cmd,
    output bdeq_pkg::dp_stat_t                  stat,
    input  logic [bdeq_pkg::REQ_W-1:0]          s_req_type,
    input  logic signed [bdeq_pkg::JOB_W-1:0]   s_job_in,
    output logic [bdeq_pkg::STAT_W-1:0]         m_status,
    output logic signed [bdeq_pkg::JOB_W-1:0]   m_job_out,
    output logic [bdeq_pkg::CNT_W-1:0]          m_entry_count
);
    import bdeq_pkg::*;

    req_t              req_reg;
    logic [JOB_W-1:0]  job_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    status_t           status_reg, status_next;
    logic [JOB_W-1:0]  job_out_reg;

    logic              is_push;
    logic              is_full;
    logic              is_empty;
    logic [IDX_W-1:0]  head_prev, head_succ, tail_prev, tail_succ;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [JOB_W-1:0]  ram_rdata;

    assign is_push  = (req_reg == REQ_PUSH_FRONT) || (req_reg == REQ_PUSH_REAR);
    assign is_full  = (count_reg == CNT_FULL);
    assign is_empty = (count_reg == '0);

    assign head_prev = (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;
    assign head_succ = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
    assign tail_prev = (tail_reg == '0) ? IDX_LAST : tail_reg - 1'b1;
    assign tail_succ = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;

    assign stat.pop_ok = !is_push && !is_empty;

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = tail_reg;
        ram_raddr   = head_reg;
        unique case (req_reg)
            REQ_PUSH_FRONT: begin
                if (is_full) begin
                    status_next = STAT_FULL;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = head_prev;
                    head_next  = head_prev;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_PUSH_REAR: begin
                if (is_full) begin
                    status_next = STAT_FULL;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = tail_reg;
                    tail_next  = tail_succ;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = head_reg;
                    head_next  = head_succ;
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_POP_REAR: begin
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = tail_prev;
                    tail_next  = tail_prev;
                    count_next = count_reg - 1'b1;
                end
            end
            default: status_next = STAT_OK;
        endcase
        if (!cmd.execute) begin
            ram_we = 1'b0;
            ram_re = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.execute) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= req_t'(s_req_type);
            job_reg <= s_job_in;
        end
        if (cmd.execute) begin
            status_reg  <= status_next;
            job_out_reg <= '0;
        end else if (cmd.take_read) begin
            job_out_reg <= ram_rdata;
        end
    end

    bdeq_ram #(
        .WIDTH (JOB_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (job_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_status      = status_reg;
    assign m_job_out     = job_out_reg;
    assign m_entry_count = count_reg;

endmodule

### rtl/bounded_double_ended_queue_top.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_req_type, s_job_in
// m_        out        m_valid / m_ready   m_status, m_job_out, m_entry_count
//
// One transaction is handled at a time. After the input transaction the controller
// passes through ST_EXEC, then ST_READ for a successful pop only, to ST_OUT where m_valid
// rises; the extra state is there because the job store is a single-port-read RAM with a
// registered read. Input is accepted again in the cycle after the result transaction
// completes. Reset clears the head, tail and count; the job store is not cleared.
// A stalled result holds until m_ready.
module bounded_double_ended_queue_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bdeq_pkg::REQ_W-1:0]          s_req_type,
    input  logic signed [bdeq_pkg::JOB_W-1:0]   s_job_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bdeq_pkg::STAT_W-1:0]         m_status,
    output logic signed [bdeq_pkg::JOB_W-1:0]   m_job_out,
    output logic [bdeq_pkg::CNT_W-1:0]          m_entry_count
);
    import bdeq_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    bdeq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bdeq_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_req_type    (s_req_type),
        .s_job_in      (s_job_in),
        .m_status      (m_status),
        .m_job_out     (m_job_out),
        .m_entry_count (m_entry_count)
    );

endmodule

### tb/deque_checker.sv
module deque_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [bdeq_pkg::REQ_W-1:0]          s_req_type,
    input  logic signed [bdeq_pkg::JOB_W-1:0]   s_job_in,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [bdeq_pkg::STAT_W-1:0]         m_status,
    input  logic signed [bdeq_pkg::JOB_W-1:0]   m_job_out,
    input  logic [bdeq_pkg::CNT_W-1:0]          m_entry_count,
    output int                                  mismatch_count,
    output int                                  pending_count,
    output int                                  request_count,
    output int                                  result_count,
    output int                                  full_count,
    output int                                  empty_count,
    output int                                  peak_count
);
    import bdeq_pkg::*;

    typedef struct packed {
        status_t                  status;
        logic signed [JOB_W-1:0]  job;
        logic [CNT_W-1:0]         count;
    } deque_result_t;

    logic signed [JOB_W-1:0] job_slots [DEPTH];
    logic [IDX_W-1:0]        head_slot;
    logic [IDX_W-1:0]        tail_slot;
    logic [CNT_W-1:0]        jobs_held;
    deque_result_t           expected_results [$];

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what,
                 $signed(got), $signed(want));
        mismatch_count++;
    endtask

    // Applies one request to the mirrored deque and returns the result it must produce.
    task apply_request(input req_t req, input logic signed [JOB_W-1:0] job,
                       output deque_result_t res);
        res.status = STAT_OK;
        res.job    = '0;
        case (req)
            REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                if (jobs_held >= CNT_FULL) begin
                    res.status = STAT_FULL;
                end else if (req == REQ_PUSH_FRONT) begin
                    head_slot = (head_slot == '0) ? IDX_LAST : head_slot - 1'b1;
                    job_slots[head_slot] = job;
                    jobs_held = jobs_held + 1'b1;
                end else begin
                    job_slots[tail_slot] = job;
                    tail_slot = (tail_slot == IDX_LAST) ? '0 : tail_slot + 1'b1;
                    jobs_held = jobs_held + 1'b1;
                end
            end
            REQ_POP_FRONT, REQ_POP_REAR: begin
                if (jobs_held == '0) begin
                    res.status = STAT_EMPTY;
                end else if (req == REQ_POP_FRONT) begin
                    res.job = job_slots[head_slot];
                    head_slot = (head_slot == IDX_LAST) ? '0 : head_slot + 1'b1;
                    jobs_held = jobs_held - 1'b1;
                end else begin
                    tail_slot = (tail_slot == '0) ? IDX_LAST : tail_slot - 1'b1;
                    res.job = job_slots[tail_slot];
                    jobs_held = jobs_held - 1'b1;
                end
            end
        endcase
        res.count = jobs_held;
    endtask

    always @(posedge aclk) begin
        deque_result_t want;
        deque_result_t next_result;
        if (!aresetn) begin
            head_slot = '0;
            tail_slot = '0;
            jobs_held = '0;
            expected_results.delete();
        end else begin
            // The result transaction is checked first, since it always belongs to an
            // earlier request.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", m_job_out, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_job_out !== want.job)
                        report_mismatch("job_out", m_job_out, want.job);
                    if (m_entry_count !== want.count)
                        report_mismatch("entry_count", m_entry_count, want.count);
                    result_count++;
                end
            end
            if (s_valid && s_ready) begin
                apply_request(req_t'(s_req_type), s_job_in, next_result);
                expected_results.push_back(next_result);
                request_count++;
                if (next_result.status == STAT_FULL)
                    full_count++;
                if (next_result.status == STAT_EMPTY)
                    empty_count++;
                if (int'(jobs_held) > peak_count)
                    peak_count = int'(jobs_held);
            end
        end
        pending_count = expected_results.size();
    end

endmodule

### tb/bounded_double_ended_queue_top_test.sv
module bounded_double_ended_queue_top_test;
    import bdeq_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 150;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [REQ_W-1:0]          s_req_type;
    logic signed [JOB_W-1:0]   s_job_in;
    logic                      m_valid;
    logic                      m_ready;
    logic [STAT_W-1:0]         m_status;
    logic signed [JOB_W-1:0]   m_job_out;
    logic [CNT_W-1:0]          m_entry_count;

    int mismatch_count;
    int pending_count;
    int request_count;
    int result_count;
    int full_count;
    int empty_count;
    int peak_count;
    int idle_cycles;
    bit sender_gaps;
    bit receiver_stalls;

    bounded_double_ended_queue_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_job_in      (s_job_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_job_out     (m_job_out),
        .m_entry_count (m_entry_count)
    );

    deque_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_job_in       (s_job_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_job_out      (m_job_out),
        .m_entry_count  (m_entry_count),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .request_count  (request_count),
        .result_count   (result_count),
        .full_count     (full_count),
        .empty_count    (empty_count),
        .peak_count     (peak_count)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [JOB_W-1:0] pick_job();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_request(input req_t req, input logic [JOB_W-1:0] job);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_job_in   <= job;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        int hold;
        hold = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (m_ready && receiver_stalls) begin
                m_ready <= 1'b0;
                hold = pick_stall() - 1;
            end else begin
                m_ready <= 1'b1;
                hold = $urandom_range(0, 15);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout with %0d results outstanding.", pending_count);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int push_bias [PHASES];
        bit is_push;
        bit at_front;
        req_t req;
        push_bias = '{90, 10, 50, 95, 5, 60, 40, 90, 15};
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_req_type      = '0;
        s_job_in        = '0;
        m_ready         = 1'b0;
        idle_cycles     = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Pops on an empty deque, both ends.
        send_request(REQ_POP_FRONT, 32'h0000_0001);
        send_request(REQ_POP_REAR, 32'hFFFF_FFFF);
        // A front push steps the head back past slot zero, and a rear pop then steps
        // the tail back past slot zero to find the same job.
        send_request(REQ_PUSH_FRONT, 32'h1234_5678);
        send_request(REQ_POP_REAR, '0);
        send_request(REQ_PUSH_REAR, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_FRONT, 32'h8000_0000);
        send_request(REQ_PUSH_REAR, 32'hFFFF_FFFF);
        send_request(REQ_PUSH_FRONT, 32'h0000_0000);
        send_request(REQ_PUSH_REAR, 32'h5555_5555);
        send_request(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
        send_request(REQ_POP_FRONT, 32'hFFFF_FFFF);
        send_request(REQ_POP_REAR, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_REAR, '0);
        send_request(REQ_POP_REAR, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_REAR, '0);

        // Each phase leans toward pushing or popping, so the deque is driven full and
        // drained empty several times with the indexes wrapping along the way.
        for (int phase = 0; phase < PHASES; phase++) begin
            sender_gaps     = (phase % 3) != 1;
            receiver_stalls = (phase % 4) != 2;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                is_push  = $urandom_range(0, 99) < push_bias[phase];
                at_front = $urandom_range(0, 1) == 1;
                if (is_push) begin
                    if (at_front) begin
                        req = REQ_PUSH_FRONT;
                    end else begin
                        req = REQ_PUSH_REAR;
                    end
                    send_request(req, pick_job());
                end else begin
                    if (at_front) begin
                        req = REQ_POP_FRONT;
                    end else begin
                        req = REQ_POP_REAR;
                    end
                    send_request(req, $urandom);
                end
            end
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d requests and checked %0d results; %0d pushes refused as full,",
                 request_count, result_count, full_count);
        $display("%0d pops refused as empty, peak occupancy %0d of %0d.",
                 empty_count, peak_count, DEPTH);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
